[rtl/crtc_pkg.sv]
package crtc_pkg;

    localparam int FIELD_W   = 8;
    localparam int STAGES    = 6;
    localparam int DAYS_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int SEC_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_24_MODE = 2'd1;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_ZERO = 2'd1;
    localparam logic [1:0] CLAMP_MAX  = 2'd2;

    typedef logic [STAGES-1:0] t_stage_en;

    typedef struct packed {
        logic [FIELD_W-1:0] sec;
        logic [FIELD_W-1:0] min;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] year;
        logic [FIELD_W-1:0] century;
    } t_fields;

endpackage

[rtl/crtc_field_dec.sv]
module crtc_field_dec (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_binary_mode,
    input  logic              i_hour_24_mode,
    input  crtc_pkg::t_fields i_fields,
    output crtc_pkg::t_fields o_fields
);
    import crtc_pkg::*;

    function automatic logic [FIELD_W-1:0] bcd_dec(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] hi;
        hi = {4'b0, v[7:4]};
        return {4'b0, v[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    function automatic logic [FIELD_W-1:0] conv(input logic [FIELD_W-1:0] v,
                                                input logic bin);
        return bin ? v : bcd_dec(v);
    endfunction

    t_fields            n_fields;
    t_fields            r_fields;
    logic [FIELD_W-1:0] hour_byte;
    logic [FIELD_W-1:0] hour_dec;
    logic               pm;

    always_comb begin
        // The PM flag comes off before the hour is decoded.
        pm        = !i_hour_24_mode && i_fields.hour[7];
        hour_byte = i_hour_24_mode ? i_fields.hour : {1'b0, i_fields.hour[6:0]};
        hour_dec  = conv(hour_byte, i_binary_mode);

        n_fields.sec     = conv(i_fields.sec, i_binary_mode);
        n_fields.min     = conv(i_fields.min, i_binary_mode);
        n_fields.day     = conv(i_fields.day, i_binary_mode);
        n_fields.month   = conv(i_fields.month, i_binary_mode);
        n_fields.year    = conv(i_fields.year, i_binary_mode);
        n_fields.century = conv(i_fields.century, i_binary_mode);
        n_fields.hour    = hour_dec;
        if (!i_hour_24_mode) begin
            if (pm && hour_dec < 8'd12) begin
                n_fields.hour = hour_dec + 8'd12;
            end else if (!pm && hour_dec == 8'd12) begin
                n_fields.hour = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fields <= n_fields;
        end
    end

    assign o_fields = r_fields;

endmodule

[rtl/crtc_day_count.sv]
module crtc_day_count (
    input  logic                               i_clk,
    input  crtc_pkg::t_stage_en                i_en,
    input  crtc_pkg::t_fields                  i_fields,
    output logic signed [crtc_pkg::DAYS_W-1:0] o_days
);
    import crtc_pkg::*;

    localparam logic [15:0] RECIP5 = 16'd52429;
    localparam logic signed [DAYS_W-1:0] ERA4_OFS = -20'sd135080;
    localparam logic signed [DAYS_W-1:0] ERA5_OFS = 20'sd11017;

    // Stage 2: full year, March-based year and month.
    logic        mle2;
    logic [11:0] base_year;
    logic [11:0] cal_year;
    logic [7:0]  shifted;
    logic [11:0] n2_yadj;
    logic [15:0] n2_t153;
    logic [11:0] r2_yadj;
    logic [15:0] r2_t153;
    logic [7:0]  r2_day;

    always_comb begin
        mle2 = i_fields.month <= 8'd2;
        if (i_fields.century inside {[8'd19:8'd21]}) begin
            case (i_fields.century)
                8'd19:   base_year = 12'd1900;
                8'd20:   base_year = 12'd2000;
                default: base_year = 12'd2100;
            endcase
        end else if (i_fields.year < 8'd70) begin
            base_year = 12'd2000;
        end else begin
            base_year = 12'd1900;
        end
        cal_year = base_year + {4'b0, i_fields.year};
        n2_yadj  = cal_year - {11'b0, mle2};
        shifted  = mle2 ? i_fields.month + 8'd9 : i_fields.month - 8'd3;
        n2_t153  = {8'b0, shifted} * 16'd153 + 16'd2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_yadj <= n2_yadj;
            r2_t153 <= n2_t153;
            r2_day  <= i_fields.day;
        end
    end

    // Stage 3: era split and day of year; the divide by five is a reciprocal multiply.
    logic               era5;
    logic [11:0]        yoe_full;
    logic [31:0]        quot_prod;
    logic [12:0]        doy_q;
    logic signed [13:0] n3_doy;
    logic               r3_era5;
    logic [8:0]         r3_yoe;
    logic signed [13:0] r3_doy;

    always_comb begin
        era5      = r2_yadj >= 12'd2000;
        yoe_full  = r2_yadj - (era5 ? 12'd2000 : 12'd1600);
        quot_prod = {16'b0, r2_t153} * {16'b0, RECIP5};
        doy_q     = quot_prod[30:18];
        n3_doy    = $signed({1'b0, doy_q}) + $signed({6'b0, r2_day}) - 14'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_era5 <= era5;
            r3_yoe  <= yoe_full[8:0];
            r3_doy  <= n3_doy;
        end
    end

    // Stage 4: day of era, then days relative to 1970-01-01.
    logic [17:0]              yoe365;
    logic [1:0]               cent;
    logic signed [DAYS_W-1:0] doe;
    logic signed [DAYS_W-1:0] n4_days;
    logic signed [DAYS_W-1:0] r4_days;

    always_comb begin
        yoe365 = {9'b0, r3_yoe} * 18'd365;
        if (r3_yoe >= 9'd300) begin
            cent = 2'd3;
        end else if (r3_yoe >= 9'd200) begin
            cent = 2'd2;
        end else if (r3_yoe >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
        doe = $signed({2'b0, yoe365}) + $signed({13'b0, r3_yoe[8:2]})
            - $signed({18'b0, cent}) + $signed({{6{r3_doy[13]}}, r3_doy});
        n4_days = doe + (r3_era5 ? ERA5_OFS : ERA4_OFS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_days <= n4_days;
        end
    end

    assign o_days = r4_days;

endmodule

[rtl/crtc_sec_total.sv]
module crtc_sec_total (
    input  logic                               i_clk,
    input  crtc_pkg::t_stage_en                i_en,
    input  crtc_pkg::t_fields                  i_fields,
    input  logic signed [crtc_pkg::DAYS_W-1:0] i_days,
    output logic [crtc_pkg::SEC_W-1:0]         o_epoch_secs,
    output logic [1:0]                         o_clamp_status
);
    import crtc_pkg::*;

    localparam int HMS_W = 20;
    localparam int TOT_W = 36;
    localparam int PRD_W = DAYS_W + 18;

    logic [HMS_W-1:0] n2_hms;
    logic [HMS_W-1:0] r2_hms;
    logic [HMS_W-1:0] r3_hms;
    logic [HMS_W-1:0] r4_hms;
    logic [HMS_W-1:0] r5_hms;

    assign n2_hms = {12'b0, i_fields.hour} * 20'd3600 + {12'b0, i_fields.min} * 20'd60
                  + {12'b0, i_fields.sec};

    // The time of day rides alongside the day count until the multiply is done.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_hms <= n2_hms;
        end
        if (i_en[2]) begin
            r3_hms <= r2_hms;
        end
        if (i_en[3]) begin
            r4_hms <= r3_hms;
        end
        if (i_en[4]) begin
            r5_hms <= r4_hms;
        end
    end

    logic signed [PRD_W-1:0] prod;
    logic signed [TOT_W-1:0] r5_prod;

    assign prod = $signed(i_days) * $signed(18'sd86400);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_prod <= prod[TOT_W-1:0];
        end
    end

    logic signed [TOT_W-1:0] total;
    logic [SEC_W-1:0]        n6_secs;
    logic [1:0]              n6_status;
    logic [SEC_W-1:0]        r6_secs;
    logic [1:0]              r6_status;

    always_comb begin
        total = r5_prod + $signed({{(TOT_W-HMS_W){1'b0}}, r5_hms});
        if (total[TOT_W-1]) begin
            n6_secs   = '0;
            n6_status = CLAMP_ZERO;
        end else if (|total[TOT_W-2:SEC_W]) begin
            n6_secs   = '1;
            n6_status = CLAMP_MAX;
        end else begin
            n6_secs   = total[SEC_W-1:0];
            n6_status = CLAMP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r6_secs   <= n6_secs;
            r6_status <= n6_status;
        end
    end

    assign o_epoch_secs   = r6_secs;
    assign o_clamp_status = r6_status;

endmodule

[rtl/cmos_rtc_to_unix_seconds.sv]
// The result passes through six register stages on its way from the edge that
// accepts the input transfer to o_valid.
// Throughput: one item per cycle while i_stall is low, with no gap needed between transfers.
// A stall on the output holds only the full stages behind it; bubbles still fill.
// Reset clears all valid bits and sets binary_mode to 0 and hour_24_mode to 1.
module cmos_rtc_to_unix_seconds (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_seconds_raw,
    input  logic [7:0]                       i_minutes_raw,
    input  logic [7:0]                       i_hours_raw,
    input  logic [7:0]                       i_day_raw,
    input  logic [7:0]                       i_month_raw,
    input  logic [7:0]                       i_year_raw,
    input  logic [7:0]                       i_century_raw,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [31:0]                      o_epoch_secs,
    output logic [1:0]                       o_clamp_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [crtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                             i_cfg_data
);
    import crtc_pkg::*;

    logic      r_binary_mode;
    logic      r_hour_24_mode;
    t_stage_en r_valid;
    t_stage_en stage_en;
    t_fields   in_fields;
    t_fields   s1_fields;
    logic signed [DAYS_W-1:0] s4_days;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode  <= 1'b0;
            r_hour_24_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BINARY_MODE:  r_binary_mode  <= i_cfg_data;
                REG_HOUR_24_MODE: r_hour_24_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[STAGES-1] = !r_valid[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    assign o_stall = !stage_en[0];
    assign o_valid = r_valid[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign in_fields.sec     = i_seconds_raw;
    assign in_fields.min     = i_minutes_raw;
    assign in_fields.hour    = i_hours_raw;
    assign in_fields.day     = i_day_raw;
    assign in_fields.month   = i_month_raw;
    assign in_fields.year    = i_year_raw;
    assign in_fields.century = i_century_raw;

    crtc_field_dec u_field_dec (
        .i_clk          (i_clk),
        .i_en           (stage_en[0]),
        .i_binary_mode  (r_binary_mode),
        .i_hour_24_mode (r_hour_24_mode),
        .i_fields       (in_fields),
        .o_fields       (s1_fields)
    );

    crtc_day_count u_day_count (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_fields (s1_fields),
        .o_days   (s4_days)
    );

    crtc_sec_total u_sec_total (
        .i_clk          (i_clk),
        .i_en           (stage_en),
        .i_fields       (s1_fields),
        .i_days         (s4_days),
        .o_epoch_secs   (o_epoch_secs),
        .o_clamp_status (o_clamp_status)
    );

    a_clamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clamp_status == CLAMP_ZERO |-> o_epoch_secs == 32'd0)
        else $error("clamp to zero with nonzero seconds");

    a_clamp_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clamp_status == CLAMP_MAX |-> o_epoch_secs == 32'hFFFF_FFFF)
        else $error("clamp to maximum with wrong seconds");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_clamp_status == CLAMP_NONE || o_clamp_status == CLAMP_ZERO
                    || o_clamp_status == CLAMP_MAX)
        else $error("undefined clamp status");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[STAGES-1] |-> !o_stall)
        else $error("input stalled while the output stage is empty");

endmodule

[tb/sv/cmos_rtc_to_unix_seconds_tb.sv]
`timescale 1ns / 100ps

module cmos_rtc_to_unix_seconds_tb;
    import crtc_pkg::*;

    localparam int     CYCLE_LIMIT = 500000;
    localparam int     LONG_HOLD   = 300;
    localparam longint SECONDS_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [SEC_W-1:0] secs;
        logic [1:0]       status;
    } t_unix_result;

    class unix_time_board;
        bit           binary_mode  = 1'b0;
        bit           hour_24_mode = 1'b1;
        t_unix_result pending[$];
        int           errors;
        int           checked;
        int           low_clamps;
        int           high_clamps;

        function void set_register(logic [CFG_IDX_W-1:0] idx, bit val);
            if (idx == REG_BINARY_MODE)
                binary_mode = val;
            else if (idx == REG_HOUR_24_MODE)
                hour_24_mode = val;
        endfunction

        function longint byte_value(logic [7:0] v);
            if (binary_mode)
                return longint'(v);
            return longint'(v[3:0]) + longint'(v[7:4]) * 10;
        endfunction

        // Works out the Unix time of one snapshot under the current register settings.
        function void note_snapshot(t_fields f);
            logic [7:0]   hour_byte;
            bit           pm;
            longint       sec, min, hour, day, month, year, century, cal_year;
            longint       y, era, yoe, shifted, doy, doe, total;
            t_unix_result res;
            hour_byte = f.hour;
            pm = 1'b0;
            if (!hour_24_mode) begin
                pm = hour_byte[7];
                hour_byte[7] = 1'b0;
            end
            sec     = byte_value(f.sec);
            min     = byte_value(f.min);
            hour    = byte_value(hour_byte);
            day     = byte_value(f.day);
            month   = byte_value(f.month);
            year    = byte_value(f.year);
            century = byte_value(f.century);
            if (!hour_24_mode) begin
                if (pm && hour < 12)
                    hour += 12;
                if (!pm && hour == 12)
                    hour = 0;
            end
            if (century >= 19 && century <= 21)
                cal_year = century * 100 + year;
            else if (year < 70)
                cal_year = 2000 + year;
            else
                cal_year = 1900 + year;

            // January, February and month zero count in the previous year.
            y = (month <= 2) ? cal_year - 1 : cal_year;
            era = y / 400;
            yoe = y - era * 400;
            shifted = (month > 2) ? month - 3 : month + 9;
            doy = (153 * shifted + 2) / 5 + day - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            total = (era * 146097 + doe - 719468) * 86400 + hour * 3600 + min * 60 + sec;

            res.status = CLAMP_NONE;
            if (total < 0) begin
                total = 0;
                res.status = CLAMP_ZERO;
            end else if (total > SECONDS_MAX) begin
                total = SECONDS_MAX;
                res.status = CLAMP_MAX;
            end
            res.secs = total[SEC_W-1:0];
            pending.push_back(res);
        endfunction

        function void check_result(logic [SEC_W-1:0] secs, logic [1:0] status);
            t_unix_result want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing outstanding: seconds %h, clamp %0d",
                         $time, secs, status);
                errors++;
            end else begin
                want = pending.pop_front();
                checked++;
                if (want.status == CLAMP_ZERO)
                    low_clamps++;
                if (want.status == CLAMP_MAX)
                    high_clamps++;
                if (secs !== want.secs) begin
                    $display("%0t: epoch seconds expected %h, actual %h",
                             $time, want.secs, secs);
                    errors++;
                end
                if (status !== want.status) begin
                    $display("%0t: clamp_status expected %0d, actual %0d",
                             $time, want.status, status);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_seconds_raw  = '0;
    logic [7:0]           i_minutes_raw  = '0;
    logic [7:0]           i_hours_raw    = '0;
    logic [7:0]           i_day_raw      = '0;
    logic [7:0]           i_month_raw    = '0;
    logic [7:0]           i_year_raw     = '0;
    logic [7:0]           i_century_raw  = '0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic [31:0]          o_epoch_secs;
    logic [1:0]           o_clamp_status;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic                 i_cfg_data     = 1'b0;

    unix_time_board board = new();
    bit             quiet_stretch = 1'b0;
    bit             long_hold_req = 1'b0;
    int             cycle_count   = 0;
    int             input_stall_cycles = 0;
    int             snapshots_sent = 0;

    cmos_rtc_to_unix_seconds i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_seconds_raw  (i_seconds_raw),
        .i_minutes_raw  (i_minutes_raw),
        .i_hours_raw    (i_hours_raw),
        .i_day_raw      (i_day_raw),
        .i_month_raw    (i_month_raw),
        .i_year_raw     (i_year_raw),
        .i_century_raw  (i_century_raw),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_epoch_secs   (o_epoch_secs),
        .o_clamp_status (o_clamp_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_fields snapshot(logic [7:0] s, logic [7:0] mi, logic [7:0] h,
                                         logic [7:0] d, logic [7:0] mo, logic [7:0] y,
                                         logic [7:0] c);
        t_fields f;
        f = '{s, mi, h, d, mo, y, c};
        return f;
    endfunction

    function automatic logic [7:0] encode(int v, bit binary);
        return binary ? 8'(v) : 8'((v / 10) * 16 + v % 10);
    endfunction

    // Mostly well-formed calendar readings in the current encoding, some with one
    // corrupted byte, and some pure noise.
    function automatic t_fields random_snapshot(bit binary, bit h24);
        t_fields f;
        int      pick;
        int      cent;
        pick = $urandom_range(0, 99);
        f.sec   = encode($urandom_range(0, 59), binary);
        f.min   = encode($urandom_range(0, 59), binary);
        if (h24)
            f.hour = encode($urandom_range(0, 23), binary);
        else
            f.hour = encode($urandom_range(1, 12), binary)
                   | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
        f.day   = encode($urandom_range(1, 31), binary);
        f.month = encode($urandom_range(1, 12), binary);
        f.year  = encode($urandom_range(0, 99), binary);
        cent = $urandom_range(0, 9);
        if (cent < 7)
            f.century = encode(19 + cent % 3, binary);
        else
            f.century = encode($urandom_range(0, 99), binary);
        if (pick < 15) begin
            f = 56'({$urandom(), $urandom()});
        end else if (pick < 25) begin
            case ($urandom_range(0, 6))
                0: f.sec     = 8'($urandom());
                1: f.min     = 8'($urandom());
                2: f.hour    = 8'($urandom());
                3: f.day     = 8'($urandom());
                4: f.month   = 8'($urandom());
                5: f.year    = 8'($urandom());
                default: f.century = 8'($urandom());
            endcase
        end
        return f;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, bit val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        board.set_register(idx, val);
    endtask

    task automatic send_snapshot(t_fields f);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_seconds_raw <= f.sec;
        i_minutes_raw <= f.min;
        i_hours_raw   <= f.hour;
        i_day_raw     <= f.day;
        i_month_raw   <= f.month;
        i_year_raw    <= f.year;
        i_century_raw <= f.century;
        do begin
            @(posedge i_clk);
            if (o_stall)
                input_stall_cycles++;
        end while (o_stall);
        board.note_snapshot(f);
        snapshots_sent++;
    endtask

    initial begin : result_sink
        int pause;
        int held;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                // Hold the output off long enough for the pipeline to back up.
                i_stall <= 1'b1;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            pause = quiet_stretch ? 0 : $urandom_range(0, 15);
            if (pause != 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            board.check_result(o_epoch_secs, o_clamp_status);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        bit         bin_cfg[5]    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        bit         h24_cfg[5]    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        logic [7:0] bcd_hours[5]  = '{8'h12, 8'h92, 8'h81, 8'h80, 8'hFF};
        logic [7:0] bin_hours[4]  = '{8'h0C, 8'h8B, 8'h7F, 8'h8C};
        int         phase;
        int         n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (phase = 0; phase < 5; phase++) begin
            if (phase != 0) begin
                // The last snapshot has been taken; stop offering it again.
                i_valid <= 1'b0;
                while (board.pending.size() != 0)
                    @(posedge i_clk);
                write_register(REG_BINARY_MODE, bin_cfg[phase]);
                write_register(REG_HOUR_24_MODE, h24_cfg[phase]);
            end
            case (phase)
                0: begin
                    // Reset settings: BCD bytes, 24-hour clock.
                    send_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19));
                    send_snapshot(snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19));
                    send_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
                    send_snapshot(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
                    send_snapshot(snapshot(8'h15, 8'h28, 8'h06, 8'h07, 8'h02, 8'h06, 8'h21));
                    send_snapshot(snapshot(8'h16, 8'h28, 8'h06, 8'h07, 8'h02, 8'h06, 8'h21));
                    send_snapshot(snapshot(8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38, 8'h20));
                    send_snapshot(snapshot(8'h30, 8'h45, 8'h12, 8'h29, 8'h02, 8'h00, 8'h20));
                    send_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h69, 8'h00));
                    send_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h70, 8'h18));
                    send_snapshot(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h99, 8'h22));
                    send_snapshot(snapshot(8'hFA, 8'hAF, 8'h99, 8'h3F, 8'h00, 8'hA5, 8'hF9));
                    send_snapshot(snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h21));
                end
                1: begin
                    send_snapshot(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
                    send_snapshot(snapshot(8'd15, 8'd28, 8'd6, 8'd7, 8'd2, 8'd6, 8'd21));
                    send_snapshot(snapshot(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd70, 8'd19));
                    // Back the pipeline up against a long output hold.
                    long_hold_req = 1'b1;
                    quiet_stretch = 1'b1;
                    for (n = 0; n < 60; n++)
                        send_snapshot(random_snapshot(1'b1, 1'b1));
                end
                2: begin
                    foreach (bcd_hours[k])
                        send_snapshot(snapshot(8'h00, 8'h00, bcd_hours[k], 8'h15, 8'h06,
                                               8'h24, 8'h20));
                end
                3: begin
                    foreach (bin_hours[k])
                        send_snapshot(snapshot(8'd0, 8'd0, bin_hours[k], 8'd15, 8'd6,
                                               8'd24, 8'd20));
                end
                default: ;
            endcase
            for (n = 0; n < 390; n++) begin
                if (n % 50 == 0)
                    quiet_stretch = ($urandom_range(0, 3) == 0);
                send_snapshot(random_snapshot(board.binary_mode, board.hour_24_mode));
            end
        end
        i_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        $display("Converted %0d snapshots in BCD and binary, 24- and 12-hour modes.",
                 snapshots_sent);
        $display("Checked %0d results (%0d clamped low, %0d clamped high); %s %0d cycles.",
                 board.checked, board.low_clamps, board.high_clamps, "input stalled",
                 input_stall_cycles);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
